// ----- sv/uss_pkg.sv -----
// shared types and constants for the utf-8 stream sanitizer
// no dependencies
package uss_pkg;

  localparam logic [7:0] AsciiLo   = 8'h01;
  localparam logic [7:0] AsciiHi   = 8'h7F;
  localparam logic [7:0] ContLo    = 8'h80;
  localparam logic [7:0] ContHi    = 8'hBF;
  localparam logic [7:0] LeadLo    = 8'hC2;
  localparam logic [7:0] Lead2Hi   = 8'hDF;
  localparam logic [7:0] Lead3Hi   = 8'hEF;
  localparam logic [7:0] LeadHi    = 8'hF4;
  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       string_end;
    logic       string_modified;
  } out_item_t;

  // one classified input byte: replacement triplets first, then literal bytes
  typedef struct packed {
    logic [3:0][7:0] lit;
    logic [2:0]      lit_cnt;
    logic [2:0]      rep_cnt;
    logic            last;
    logic            modified;
  } job_t;

endpackage

// ----- sv/uss_front.sv -----
// front end: accepts input bytes, tracks the open sequence, emits jobs
// depends on uss_pkg
module uss_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uss_pkg::in_item_t in_data_i,
  input  logic             replace_mode_i,
  input  logic             full_i,
  output logic             push_o,
  output uss_pkg::job_t    job_o
);
  import uss_pkg::*;

  logic       seq_open_q, seq_open_d;
  logic [7:0] lead_q, lead_d;
  logic [1:0] held_q, held_d;
  logic [1:0] need_q, need_d;
  logic       changed_q, changed_d;
  logic [1:0][7:0] cont_q;

  logic [7:0] b;
  logic       accept, is_cont, is_ascii, is_lead, complete, hold, brk;
  logic [1:0] need_new;
  logic [2:0] inv;
  logic [2:0] lit_cnt;
  logic [3:0][7:0] lit;
  logic       open_after;
  logic [1:0] held_after;

  assign b          = in_data_i.in_byte;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    is_cont  = (b inside {[ContLo:ContHi]});
    is_ascii = (b inside {[AsciiLo:AsciiHi]});
    is_lead  = (b inside {[LeadLo:LeadHi]});
    need_new = (b <= Lead2Hi) ? 2'd1 : ((b <= Lead3Hi) ? 2'd2 : 2'd3);
    complete = seq_open_q && is_cont && ({1'b0, held_q} + 3'd1 >= {1'b0, need_q});
    hold     = seq_open_q && is_cont && !complete;
    brk      = seq_open_q && !is_cont;

    lit        = '{default: 8'h00};
    lit_cnt    = 3'd0;
    inv        = 3'd0;
    open_after = 1'b0;
    held_after = 2'd0;
    seq_open_d = seq_open_q;
    lead_d     = lead_q;
    held_d     = held_q;
    need_d     = need_q;

    if (complete) begin
      lit[0]     = lead_q;
      lit[1]     = (held_q == 2'd0) ? b : cont_q[0];
      lit[2]     = (held_q == 2'd1) ? b : cont_q[1];
      lit[3]     = b;
      lit_cnt    = {1'b0, held_q} + 3'd2;
      seq_open_d = 1'b0;
      lead_d     = 8'h00;
      held_d     = 2'd0;
      need_d     = 2'd0;
    end else if (hold) begin
      open_after = 1'b1;
      held_after = held_q + 2'd1;
      held_d     = held_after;
    end else begin
      if (brk) begin
        inv = {1'b0, held_q} + 3'd1;
      end
      seq_open_d = 1'b0;
      lead_d     = 8'h00;
      held_d     = 2'd0;
      need_d     = 2'd0;
      if (is_ascii) begin
        lit[0]  = b;
        lit_cnt = 3'd1;
      end else if (is_lead) begin
        open_after = 1'b1;
        seq_open_d = 1'b1;
        lead_d     = b;
        need_d     = need_new;
      end else begin
        inv = inv + 3'd1;
      end
    end

    // string ends with a sequence still open
    if (in_data_i.in_last && open_after) begin
      inv = inv + {1'b0, held_after} + 3'd1;
    end

    changed_d = changed_q || (inv != 3'd0);
    if (in_data_i.in_last) begin
      seq_open_d = 1'b0;
      lead_d     = 8'h00;
      held_d     = 2'd0;
      need_d     = 2'd0;
      changed_d  = 1'b0;
    end

    job_o.lit      = lit;
    job_o.lit_cnt  = lit_cnt;
    job_o.rep_cnt  = replace_mode_i ? inv : 3'd0;
    job_o.last     = in_data_i.in_last;
    job_o.modified = changed_q || (inv != 3'd0);
  end

  assign push_o = accept &&
                  (lit_cnt != 3'd0 || job_o.rep_cnt != 3'd0 || in_data_i.in_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_open_q <= 1'b0;
      lead_q     <= 8'h00;
      held_q     <= 2'd0;
      need_q     <= 2'd0;
      changed_q  <= 1'b0;
    end else if (accept) begin
      seq_open_q <= seq_open_d;
      lead_q     <= lead_d;
      held_q     <= held_d;
      need_q     <= need_d;
      changed_q  <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold) begin
      cont_q[held_q[0]] <= b;
    end
  end

endmodule

// ----- sv/uss_fifo.sv -----
// job queue between front and back end
// depends on uss_pkg
module uss_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uss_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output uss_pkg::job_t rdata_o
);
  import uss_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/uss_back.sv -----
// back end: expands one job into result transactions through an output register
// depends on uss_pkg
module uss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  uss_pkg::job_t       job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output uss_pkg::out_item_t  out_data_o
);
  import uss_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic [4:0] rep3, total, n;
  logic       bare, fin, load;
  logic [1:0] lit_idx;
  logic [4:0] lit_off;

  function automatic logic [7:0] repl_byte(logic [3:0] p);
    case (p)
      4'd0, 4'd3, 4'd6, 4'd9:  return ReplByte0;
      4'd1, 4'd4, 4'd7, 4'd10: return ReplByte1;
      default:                 return ReplByte2;
    endcase
  endfunction

  always_comb begin
    rep3    = ({2'b00, job_i.rep_cnt} << 1) + {2'b00, job_i.rep_cnt};
    total   = rep3 + {2'b00, job_i.lit_cnt};
    bare    = (total == 5'd0);
    n       = bare ? 5'd1 : total;
    fin     = ({1'b0, pos_q} == n - 5'd1);
    lit_off = {1'b0, pos_q} - rep3;
    lit_idx = lit_off[1:0];
    load    = !empty_i && (!out_valid_q || !out_stall_i);

    out_d = out_q;
    if (bare) begin
      out_d.out_byte     = 8'h00;
      out_d.byte_present = 1'b0;
    end else if ({1'b0, pos_q} < rep3) begin
      out_d.out_byte     = repl_byte(pos_q);
      out_d.byte_present = 1'b1;
    end else begin
      out_d.out_byte     = job_i.lit[lit_idx];
      out_d.byte_present = 1'b1;
    end
    out_d.run_last        = fin;
    out_d.string_end      = fin && job_i.last;
    out_d.string_modified = fin && job_i.last && job_i.modified;

    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = fin ? 4'd0 : pos_q + 4'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pop_o       = load && fin;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- sv/utf8_stream_sanitizer_top.sv -----
// utf-8 stream sanitizer, top level
// depends on uss_pkg, uss_front, uss_fifo, uss_back
// path: the queue entry is written at acceptance, then the output register is loaded
// throughput: one input byte per cycle while the queue is not full; back end sends one
//   result per cycle when not stalled; up to 12 results per byte, queue absorbs bursts
// reset: async active low, clears sequence state, queue, output valid and replace_mode
module utf8_stream_sanitizer_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uss_pkg::in_item_t  in_data_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uss_pkg::out_item_t out_data_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import uss_pkg::*;

  // replace_mode register, always writable
  logic replace_mode_q;

  // front to queue
  logic push, full;
  job_t push_job;

  // queue to back end
  logic pop, empty;
  job_t head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      replace_mode_q <= cfg_data_i;
    end
  end

  // front end classifies each byte into a job: replacement count plus literal bytes
  uss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .replace_mode_i (replace_mode_q),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // decouples byte intake from result expansion
  uss_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_job)
  );

  // back end walks each job one result transaction per cycle while the output is not stalled
  uss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/uss_checker.sv -----
// port-level checks for the utf-8 stream sanitizer, bound to the top level
// depends on uss_pkg and utf8_stream_sanitizer_top
module uss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input uss_pkg::out_item_t out_data_o
);
  import uss_pkg::*;

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_end |-> out_data_o.run_last)
    else $error("string end without run last");

  a_mod_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_modified |-> out_data_o.string_end)
    else $error("modified flag away from string end");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_present |->
      out_data_o.string_end && out_data_o.out_byte == 8'h00)
    else $error("bad bare end marker");

endmodule

bind utf8_stream_sanitizer_top uss_checker u_uss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
